// ----- hw/rtl/acc_alu_pkg.sv -----
// Shared types and constants for the accumulator ALU.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package acc_alu_pkg;

   // Accumulator width; the operand and result ports stay at 32 bits.
   localparam int ACC_WIDTH = 32;
   localparam int CNT_W     = $clog2(ACC_WIDTH);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ACC_WIDTH - 1);

   // Operation codes of the request word.
   typedef enum logic [2:0] {
      MODE_SET     = 3'd0,
      MODE_ADD     = 3'd1,
      MODE_SUB     = 3'd2,
      MODE_MUL     = 3'd3,
      MODE_DIV     = 3'd4,
      MODE_MOD     = 3'd5,
      MODE_PRINT   = 3'd6,
      MODE_INVALID = 3'd7
   } mode_type;

   // Status codes of the response word.
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_DIV_ZERO = 2'd1,
      STATUS_BAD_OP   = 2'd2
   } status_type;

   // Sequencer states, one-hot.
   typedef enum logic [6:0] {
      ST_IDLE = 7'b000_0001,
      ST_EXEC = 7'b000_0010,
      ST_NEGB = 7'b000_0100,
      ST_MUL  = 7'b000_1000,
      ST_DIV  = 7'b001_0000,
      ST_FIX  = 7'b010_0000,
      ST_DONE = 7'b100_0000
   } state_type;

   // Control from the sequencer to the datapath.
   typedef struct packed {
      state_type state;
      mode_type  mode;
      logic      load;
      logic      start;
   } ctl_type;

   // Status from the datapath back to the sequencer.
   typedef struct packed {
      logic y_zero;
   } sts_type;

endpackage

// ----- hw/rtl/acc_alu_addsub.sv -----
// Shared adder/subtractor of the accumulator ALU, with carry out.
// Depends on acc_alu_pkg for the accumulator width.
`timescale 1ns / 1ps

module acc_alu_addsub (
   input  logic [acc_alu_pkg::ACC_WIDTH-1:0] op_a,
   input  logic [acc_alu_pkg::ACC_WIDTH-1:0] op_b,
   input  logic                              sub,
   output logic [acc_alu_pkg::ACC_WIDTH-1:0] sum,
   output logic                              carry
);
   import acc_alu_pkg::*;

   logic [ACC_WIDTH-1:0] op_b_inv;

   // Subtraction is a plus the inverted b plus one; carry high means no borrow.
   assign op_b_inv = op_b ^ {ACC_WIDTH{sub}};
   assign {carry, sum} = {1'b0, op_a} + {1'b0, op_b_inv} + (ACC_WIDTH + 1)'(sub);

endmodule

// ----- hw/rtl/acc_alu_dp.sv -----
// Datapath of the accumulator ALU: accumulator, work registers and the
// shared adder. Depends on acc_alu_pkg and acc_alu_addsub.
`timescale 1ns / 1ps

module acc_alu_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  acc_alu_pkg::ctl_type              ctl,
   input  logic signed [31:0]                operand,
   output acc_alu_pkg::sts_type              sts,
   output logic [acc_alu_pkg::ACC_WIDTH-1:0] acc
);
   import acc_alu_pkg::*;

   logic [ACC_WIDTH-1:0] acc_ff, acc_in;
   logic [ACC_WIDTH-1:0] x_ff, x_in;
   logic [ACC_WIDTH-1:0] y_ff, y_in;
   logic [ACC_WIDTH-1:0] r_ff, r_in;
   logic                 neg_ff, neg_in;

   logic [ACC_WIDTH-1:0] unit_a, unit_b, unit_sum;
   logic                 unit_sub, unit_carry;
   logic [ACC_WIDTH-1:0] operand_fit, shifted, start_acc;

   // Operand is sign-extended or cut to the accumulator width.
   assign operand_fit = ACC_WIDTH'(operand);
   assign start_acc   = ctl.start ? '0 : acc_ff;
   // Partial remainder shifted left with the next dividend bit.
   assign shifted     = {r_ff[ACC_WIDTH-2:0], x_ff[ACC_WIDTH-1]};

   acc_alu_addsub u_addsub (
      .op_a  (unit_a),
      .op_b  (unit_b),
      .sub   (unit_sub),
      .sum   (unit_sum),
      .carry (unit_carry)
   );

   // Select the inputs of the shared adder for each step.
   always_comb begin
      unit_a   = x_ff;
      unit_b   = y_ff;
      unit_sub = 1'b0;
      case (ctl.state)
         ST_EXEC: begin
            if (ctl.mode == MODE_DIV || ctl.mode == MODE_MOD) begin
               unit_a   = '0;
               unit_b   = x_ff;
               unit_sub = 1'b1;
            end else begin
               unit_sub = (ctl.mode == MODE_SUB);
            end
         end
         ST_NEGB: begin
            unit_a   = '0;
            unit_b   = y_ff;
            unit_sub = 1'b1;
         end
         ST_MUL: begin
            unit_a = r_ff;
            unit_b = x_ff;
         end
         ST_DIV: begin
            unit_a   = shifted;
            unit_b   = y_ff;
            unit_sub = 1'b1;
         end
         ST_FIX: begin
            unit_a   = '0;
            unit_b   = (ctl.mode == MODE_DIV) ? x_ff : r_ff;
            unit_sub = neg_ff;
         end
         default: begin
            unit_sub = 1'b0;
         end
      endcase
   end

   // Next values of the accumulator and the work registers.
   always_comb begin
      acc_in = acc_ff;
      x_in   = x_ff;
      y_in   = y_ff;
      r_in   = r_ff;
      neg_in = neg_ff;
      if (ctl.load) begin
         acc_in = start_acc;
         x_in   = start_acc;
         y_in   = operand_fit;
      end else begin
         case (ctl.state)
            ST_EXEC: begin
               r_in = '0;
               case (ctl.mode)
                  MODE_SET: acc_in = y_ff;
                  MODE_ADD, MODE_SUB: acc_in = unit_sum;
                  MODE_MUL: neg_in = 1'b0;
                  MODE_DIV, MODE_MOD: begin
                     // Take the magnitude of the dividend and note the result sign.
                     if (x_ff[ACC_WIDTH-1]) begin
                        x_in = unit_sum;
                     end
                     neg_in = (ctl.mode == MODE_DIV) ?
                              (x_ff[ACC_WIDTH-1] ^ y_ff[ACC_WIDTH-1]) : x_ff[ACC_WIDTH-1];
                  end
                  default: neg_in = neg_ff;
               endcase
            end
            ST_NEGB: begin
               if (y_ff[ACC_WIDTH-1]) begin
                  y_in = unit_sum;
               end
            end
            ST_MUL: begin
               // Shift-and-add: one multiplier bit per cycle.
               if (y_ff[0]) begin
                  r_in = unit_sum;
               end
               x_in = {x_ff[ACC_WIDTH-2:0], 1'b0};
               y_in = {1'b0, y_ff[ACC_WIDTH-1:1]};
            end
            ST_DIV: begin
               // Restoring division: one quotient bit per cycle.
               r_in = unit_carry ? unit_sum : shifted;
               x_in = {x_ff[ACC_WIDTH-2:0], unit_carry};
            end
            ST_FIX: begin
               acc_in = unit_sum;
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      r_ff   <= r_in;
      neg_ff <= neg_in;
   end

   assign sts.y_zero = (y_ff == '0);
   assign acc        = acc_ff;

endmodule

// ----- hw/rtl/acc_alu_ctrl.sv -----
// Sequencer of the accumulator ALU: state machine, step counter and the
// response register. Depends on acc_alu_pkg.
`timescale 1ns / 1ps

module acc_alu_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [2:0]                        req_mode,
   input  logic                              req_start_of_run,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [31:0]                rsp_acc_value,
   output logic [1:0]                        rsp_status,
   output logic                              rsp_print_request,
   input  acc_alu_pkg::sts_type              sts,
   input  logic [acc_alu_pkg::ACC_WIDTH-1:0] acc,
   output acc_alu_pkg::ctl_type              ctl
);
   import acc_alu_pkg::*;

   state_type          state_ff, state_in;
   mode_type           mode_ff, mode_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   status_type         status_ff, status_in;
   logic               print_ff, print_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_acc_ff, rsp_acc_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic               rsp_print_ff, rsp_print_in;
   logic               accept, out_load;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // Step sequencing.
   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      cnt_in    = cnt_ff;
      status_in = status_ff;
      print_in  = print_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in  = mode_type'(req_mode);
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            status_in = STATUS_OK;
            print_in  = 1'b0;
            cnt_in    = '0;
            state_in  = ST_DONE;
            case (mode_ff)
               MODE_SET, MODE_ADD, MODE_SUB: state_in = ST_DONE;
               MODE_MUL: state_in = ST_MUL;
               MODE_DIV, MODE_MOD: begin
                  if (sts.y_zero) begin
                     status_in = STATUS_DIV_ZERO;
                  end else begin
                     state_in = ST_NEGB;
                  end
               end
               MODE_PRINT: print_in = 1'b1;
               default: status_in = STATUS_BAD_OP;
            endcase
         end
         ST_NEGB: begin
            state_in = ST_DIV;
         end
         ST_MUL, ST_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response register: holds a finished word until the receiver takes it.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_acc_in    = rsp_acc_ff;
      rsp_status_in = rsp_status_ff;
      rsp_print_in  = rsp_print_ff;
      if (out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_acc_in    = 32'(signed'(acc));
         rsp_status_in = status_ff;
         rsp_print_in  = print_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      cnt_ff        <= cnt_in;
      status_ff     <= status_in;
      print_ff      <= print_in;
      rsp_acc_ff    <= rsp_acc_in;
      rsp_status_ff <= rsp_status_in;
      rsp_print_ff  <= rsp_print_in;
   end

   assign ctl.state = state_ff;
   assign ctl.mode  = mode_ff;
   assign ctl.load  = accept;
   assign ctl.start = req_start_of_run;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_acc_value     = rsp_acc_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_print_request = rsp_print_ff;

endmodule

// ----- hw/rtl/accumulator_alu_unit.sv -----
// Top level of the accumulator ALU: sequencer plus datapath.
// Depends on acc_alu_pkg, acc_alu_ctrl and acc_alu_dp.
//
// Usage:
//   The request channel (req_*) carries one decoded operation per word: a
//   mode, a signed 32-bit operand and a start-of-run flag that zeroes the
//   accumulator first. The response channel (rsp_*) returns one word per
//   request: the accumulator after the operation, a status code and a print
//   flag. Both channels use valid/ready.
//   Set, add, subtract, print, bad opcode and divide by zero finish in the
//   execute step; multiply runs the shift-and-add loop over the shared
//   adder; divide and remainder run the restoring division loop on the
//   same adder plus the sign fixups.
//   One request is worked on at a time; req_ready rises at the edge that
//   loads the response word, so the next request is taken only after the
//   previous one has finished.
//   The response register lets a new request enter while the previous word
//   still waits; if the receiver stalls, a finished result waits in the
//   sequencer until the register frees up.
//   Synchronous reset clears the accumulator to zero and empties both
//   channels.
`timescale 1ns / 1ps

module accumulator_alu_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_mode,
   input  logic signed [31:0] req_operand,
   input  logic               req_start_of_run,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_acc_value,
   output logic [1:0]         rsp_status,
   output logic               rsp_print_request
);
   import acc_alu_pkg::*;

   ctl_type              ctl;
   sts_type              sts;
   logic [ACC_WIDTH-1:0] acc;

   acc_alu_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_start_of_run  (req_start_of_run),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_acc_value     (rsp_acc_value),
      .rsp_status        (rsp_status),
      .rsp_print_request (rsp_print_request),
      .sts               (sts),
      .acc               (acc),
      .ctl               (ctl)
   );

   acc_alu_dp u_dp (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .operand (req_operand),
      .sts     (sts),
      .acc     (acc)
   );

endmodule

// ----- hw/rtl/acc_alu_checker.sv -----
// Port-level checks for the accumulator ALU, bound to the top level.
// Depends on acc_alu_pkg and accumulator_alu_unit.
`timescale 1ns / 1ps

module acc_alu_port_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [2:0]         req_mode,
   input logic signed [31:0] req_operand,
   input logic               req_start_of_run,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_acc_value,
   input logic [1:0]         rsp_status,
   input logic               rsp_print_request
);
   import acc_alu_pkg::*;

   // A stalled response word holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_acc_value) &&
      $stable(rsp_status) && $stable(rsp_print_request))
      else $error("response word changed while stalled");

   // A waiting request word holds its value until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_mode) &&
      $stable(req_operand) && $stable(req_start_of_run))
      else $error("request word changed while waiting");

   // The block takes one word at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a word is in flight");

   // A print request always comes with an ok status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_print_request |-> rsp_status == STATUS_OK)
      else $error("print request with an error status");

   // Accepting a request while no response waits does not itself raise a response.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("response appeared right after acceptance");

endmodule

bind accumulator_alu_unit acc_alu_port_checker u_acc_alu_checker (.*);

// ----- test/acc_alu_checker.sv -----
// Checker for the accumulator ALU: watches both channels, predicts each response word
// and compares it with what the block returns.
// Depends on acc_alu_pkg for the mode and status codes and the accumulator width.
`timescale 1ns / 1ps

module acc_alu_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [2:0]         req_mode,
   input  logic signed [31:0] req_operand,
   input  logic               req_start_of_run,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_acc_value,
   input  logic [1:0]         rsp_status,
   input  logic               rsp_print_request,
   output int                 pending,
   output int                 fail_count
);
   import acc_alu_pkg::*;

   // One predicted response word.
   typedef struct {
      logic signed [31:0] acc_value;
      status_type         status;
      logic               print_request;
   } rsp_word_type;

   logic [ACC_WIDTH-1:0] model_acc;
   rsp_word_type         expected_words[$];

   initial begin
      pending    = 0;
      fail_count = 0;
      model_acc  = '0;
   end

   // Print one mismatch line and count it.
   task automatic report_mismatch(input string msg);
      $display("acc_alu_checker: mismatch at %0t ns: %s", $time, msg);
      fail_count++;
   endtask

   // Apply one operation to the predicted accumulator and return the response word.
   function automatic rsp_word_type predict_word(input mode_type mode,
                                                 input logic signed [31:0] operand,
                                                 input logic start);
      logic signed [ACC_WIDTH-1:0] a;
      logic signed [ACC_WIDTH-1:0] b;
      logic [ACC_WIDTH-1:0]        ua;
      logic [ACC_WIDTH-1:0]        ub;
      logic [ACC_WIDTH-1:0]        r;
      rsp_word_type                w;
      if (start) begin
         model_acc = '0;
      end
      a = model_acc;
      // The operand is sign-extended or cut to the accumulator width.
      b = operand;
      ua = a[ACC_WIDTH-1] ? -a : a;
      ub = b[ACC_WIDTH-1] ? -b : b;
      w.status        = STATUS_OK;
      w.print_request = 1'b0;
      case (mode)
         MODE_SET: model_acc = b;
         MODE_ADD: model_acc = a + b;
         MODE_SUB: model_acc = a - b;
         MODE_MUL: model_acc = a * b;
         MODE_DIV, MODE_MOD: begin
            if (b == 0) begin
               w.status = STATUS_DIV_ZERO;
            end else if (mode == MODE_DIV) begin
               // Quotient truncates toward zero; the minimum over minus one wraps to itself.
               r = ua / ub;
               if (a[ACC_WIDTH-1] != b[ACC_WIDTH-1]) r = -r;
               model_acc = r;
            end else begin
               // Remainder takes the sign of the dividend.
               r = ua % ub;
               if (a[ACC_WIDTH-1]) r = -r;
               model_acc = r;
            end
         end
         MODE_PRINT: w.print_request = 1'b1;
         default: w.status = STATUS_BAD_OP;
      endcase
      w.acc_value = signed'(model_acc);
      return w;
   endfunction

   // Compare responses against the oldest prediction, then record new requests.
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         expected_words.delete();
         model_acc = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               report_mismatch("response word with no request outstanding");
            end else begin
               want = expected_words.pop_front();
               if (rsp_acc_value !== want.acc_value)
                  report_mismatch($sformatf("acc_value got %0d expected %0d",
                                            rsp_acc_value, want.acc_value));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status got %0d expected %0d",
                                            rsp_status, want.status));
               if (rsp_print_request !== want.print_request)
                  report_mismatch($sformatf("print_request got %0b expected %0b",
                                            rsp_print_request, want.print_request));
            end
         end
         if (req_valid && req_ready)
            expected_words.push_back(predict_word(mode_type'(req_mode), req_operand,
                                                  req_start_of_run));
      end
      pending = expected_words.size();
   end

endmodule

// ----- test/tb_top.sv -----
// Testbench top for the accumulator ALU: clock, reset, request stimulus, response stalls
// and the verdict. Depends on acc_alu_pkg, accumulator_alu_unit and acc_alu_checker.
`timescale 1ns / 1ps

module tb_top;
   import acc_alu_pkg::*;

   localparam int IDLE_LIMIT  = 4000;
   localparam int PHASE_WORDS = 482;

   logic               clock             = 1'b0;
   logic               reset             = 1'b1;
   logic               req_valid         = 1'b0;
   logic               req_ready;
   logic [2:0]         req_mode          = MODE_SET;
   logic signed [31:0] req_operand       = '0;
   logic               req_start_of_run  = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready         = 1'b0;
   logic signed [31:0] rsp_acc_value;
   logic [1:0]         rsp_status;
   logic               rsp_print_request;

   int pending;
   int fail_count;
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int quiet_cycles  = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   accumulator_alu_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_operand       (req_operand),
      .req_start_of_run  (req_start_of_run),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_acc_value     (rsp_acc_value),
      .rsp_status        (rsp_status),
      .rsp_print_request (rsp_print_request)
   );

   acc_alu_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_operand       (req_operand),
      .req_start_of_run  (req_start_of_run),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_acc_value     (rsp_acc_value),
      .rsp_status        (rsp_status),
      .rsp_print_request (rsp_print_request),
      .pending           (pending),
      .fail_count        (fail_count)
   );

   // The receiver stalls at random with the current phase's percentage.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Watchdog: end the run if neither channel moves a word for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one request word; called and left just after a falling edge. Valid stays
   // high after acceptance so that a following word does not drop it in the same step.
   task automatic send_word(input mode_type mode, input logic [31:0] operand,
                            input logic start);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_operand      <= operand;
      req_start_of_run <= start;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Hold off new requests until every response word has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // Operand mix: full range, small values around zero, extremes and mid-size values.
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom();
         4, 5, 6:    return $urandom_range(0, 16) - 8;
         7: begin
            case ($urandom_range(0, 4))
               0:       return 32'h8000_0000;
               1:       return 32'h7fff_ffff;
               2:       return 32'h0000_0000;
               3:       return 32'hffff_ffff;
               default: return 32'h0000_0001;
            endcase
         end
         default: return $urandom_range(0, 1) ? -$urandom_range(0, 65535)
                                               : $urandom_range(0, 65535);
      endcase
   endfunction

   task automatic run_phase(input int idle_pct, input int stall_pct);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (PHASE_WORDS)
         send_word(mode_type'($urandom_range(0, 7)), pick_operand(),
                   $urandom_range(0, 7) == 0);
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed words: wrap-around, division corners, errors, print and start flag.
      send_word(MODE_SET, 32'd0, 1'b1);
      send_word(MODE_SET, 32'h7fff_ffff, 1'b0);
      send_word(MODE_ADD, 32'd1, 1'b0);
      send_word(MODE_SUB, 32'd1, 1'b0);
      send_word(MODE_MUL, 32'h7fff_ffff, 1'b0);
      send_word(MODE_SET, 32'h8000_0000, 1'b0);
      send_word(MODE_DIV, 32'hffff_ffff, 1'b0);
      send_word(MODE_MOD, 32'hffff_ffff, 1'b0);
      send_word(MODE_SET, -32'sd7, 1'b0);
      send_word(MODE_DIV, 32'd2, 1'b0);
      send_word(MODE_SET, -32'sd7, 1'b0);
      send_word(MODE_MOD, 32'd2, 1'b0);
      send_word(MODE_SET, 32'd7, 1'b0);
      send_word(MODE_MOD, -32'sd2, 1'b0);
      send_word(MODE_DIV, 32'd0, 1'b0);
      send_word(MODE_MOD, 32'd0, 1'b0);
      send_word(MODE_INVALID, 32'hffff_ffff, 1'b0);
      send_word(MODE_PRINT, 32'h1234_5678, 1'b0);
      send_word(MODE_DIV, 32'd0, 1'b1);
      send_word(MODE_SET, 32'd9, 1'b0);
      send_word(MODE_INVALID, 32'd0, 1'b1);
      send_word(MODE_ADD, 32'd5, 1'b1);
      send_word(MODE_PRINT, 32'd0, 1'b1);
      wait_drained();

      // Random words per idling pattern, draining after each phase but the second.
      run_phase(0, 0);
      wait_drained();
      run_phase(46, 0);
      run_phase(0, 46);
      wait_drained();
      run_phase(32, 32);

      wait_drained();
      repeat (40) @(negedge clock);
      if (fail_count == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
